[rtl/rc6_pkg.sv]
package rc6_pkg;

  localparam int unsigned RC6_ROUNDS = 20;

  localparam logic [31:0] RC6_P32 = 32'hb7e15163;
  localparam logic [31:0] RC6_Q32 = 32'h9e3779b9;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_KEY0    = 3'd0,
    CFG_KEY1    = 3'd1,
    CFG_KEY2    = 3'd2,
    CFG_KEY3    = 3'd3,
    CFG_KEYLEN  = 3'd4,
    CFG_DECRYPT = 3'd5
  } cfg_idx_e;

  // key length codes
  localparam logic [1:0] KEYLEN_128 = 2'd0;
  localparam logic [1:0] KEYLEN_192 = 2'd1;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] w;
    w = {x, x} << n;
    return w[63:32];
  endfunction

  function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] w;
    w = {x, x} >> n;
    return w[31:0];
  endfunction

endpackage

[rtl/rc6_block_cipher_core.sv]
// RC6-32/ROUNDS block cipher, one 128-bit block per request, direction and key
// (128, 192 or 256 bits) set through the write port. After reset or any write to
// the key, key length or direction registers, the next block first builds the
// round keys in 3*(2*ROUNDS+4) mixing steps, each a KSA and a KSB state, after
// which the keys are kept. A block then passes a whitening state on each side (PRE,
// POST) and, per round, the states MT and MU on the single shared 32x32 multiplier
// and the update state UPD before the next block can be taken. The round keys
// live in two banks (even and odd words) with registered reads. A finished block
// waits in the output register while the next one is accepted.
module rc6_block_cipher_core #(
  parameter int unsigned ROUNDS = rc6_pkg::RC6_ROUNDS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [63:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // block_low, block_high
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata    // result_low, result_high
);

  localparam int unsigned NP    = ROUNDS + 2;
  localparam int unsigned NKEYS = 2 * NP;
  localparam int unsigned PW    = $clog2(NP);
  localparam int unsigned KW    = PW + 1;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_KSA  = 8'b0000_0010,
    ST_KSB  = 8'b0000_0100,
    ST_PRE  = 8'b0000_1000,
    ST_MT   = 8'b0001_0000,
    ST_MU   = 8'b0010_0000,
    ST_UPD  = 8'b0100_0000,
    ST_POST = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [63:0] key_q [4];
  logic [1:0]  klen_q;
  logic        dec_q;
  logic        ready_q, ready_d;

  logic [31:0] wa_q, wb_q, wc_q, wd_q, wa_d, wb_d, wc_d, wd_d;
  logic [31:0] t_q, u_q, t_d, u_d;
  logic [31:0] ka_q, kb_q, ka_d, kb_d;
  logic [31:0] init_q, init_d;
  logic [31:0] lw_q [8];
  logic [KW-1:0] k_q, k_d;
  logic [2:0]  j_q, j_d;
  logic [1:0]  pass_q, pass_d;
  logic [PW-1:0] pair_q, pair_d, rd_pair;
  logic [127:0] out_q, out_d;
  logic        out_valid_q, out_valid_d;

  logic [31:0] even_mem [NP];
  logic [31:0] odd_mem  [NP];
  logic [31:0] rk_even_q, rk_odd_q;

  logic        in_req;
  logic        lw_load;
  logic [3:0]  nkw;
  logic        k_last, j_last, rnd_last;
  logic [31:0] s_src, ab, mix_op, prod, mixv;
  logic [PW-1:0] pair_first;

  assign in_req        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  always_comb begin
    unique case (klen_q)
      rc6_pkg::KEYLEN_128: nkw = 4'd4;
      rc6_pkg::KEYLEN_192: nkw = 4'd6;
      default:             nkw = 4'd8;
    endcase
  end

  assign k_last     = (k_q == KW'(NKEYS - 1));
  assign j_last     = ({1'b0, j_q} == (nkw - 4'd1));
  assign rnd_last   = dec_q ? (pair_q == PW'(1)) : (pair_q == PW'(ROUNDS));
  assign pair_first = dec_q ? PW'(ROUNDS + 1) : '0;

  assign s_src  = (pass_q == 2'd0) ? init_q : (k_q[0] ? rk_odd_q : rk_even_q);
  assign ab     = ka_q + kb_q;
  assign mix_op = (state_q == ST_MT) ? (dec_q ? wa_q : wb_q) : (dec_q ? wc_q : wd_q);
  assign prod   = mix_op * {mix_op[30:0], 1'b1};
  assign mixv   = rc6_pkg::rotl32(prod, 5'd5);

  always_comb begin
    state_d     = state_q;
    ready_d     = ready_q;
    wa_d        = wa_q;
    wb_d        = wb_q;
    wc_d        = wc_q;
    wd_d        = wd_q;
    t_d         = t_q;
    u_d         = u_q;
    ka_d        = ka_q;
    kb_d        = kb_q;
    init_d      = init_q;
    k_d         = k_q;
    j_d         = j_q;
    pass_d      = pass_q;
    pair_d      = pair_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    lw_load     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_req) begin
          wa_d = s_axis_tdata[31:0];
          wb_d = s_axis_tdata[63:32];
          wc_d = s_axis_tdata[95:64];
          wd_d = s_axis_tdata[127:96];
          if (ready_q) begin
            pair_d  = pair_first;
            state_d = ST_PRE;
          end else begin
            lw_load = 1'b1;
            k_d     = '0;
            j_d     = '0;
            pass_d  = '0;
            init_d  = rc6_pkg::RC6_P32;
            ka_d    = '0;
            kb_d    = '0;
            state_d = ST_KSA;
          end
        end
      end
      ST_KSA: begin
        ka_d    = rc6_pkg::rotl32(s_src + ka_q + kb_q, 5'd3);
        init_d  = init_q + rc6_pkg::RC6_Q32;
        state_d = ST_KSB;
      end
      ST_KSB: begin
        kb_d   = rc6_pkg::rotl32(lw_q[j_q] + ab, ab[4:0]);
        k_d    = k_last ? '0 : k_q + KW'(1);
        j_d    = j_last ? '0 : j_q + 3'd1;
        pass_d = k_last ? pass_q + 2'd1 : pass_q;
        if (k_last && pass_q == 2'd2) begin
          ready_d = 1'b1;
          pair_d  = pair_first;
          state_d = ST_PRE;
        end else begin
          state_d = ST_KSA;
        end
      end
      ST_PRE: begin
        if (dec_q) begin
          wa_d   = wa_q - rk_even_q;
          wc_d   = wc_q - rk_odd_q;
          pair_d = PW'(ROUNDS);
        end else begin
          wb_d   = wb_q + rk_even_q;
          wd_d   = wd_q + rk_odd_q;
          pair_d = PW'(1);
        end
        state_d = ST_MT;
      end
      ST_MT: begin
        t_d     = mixv;
        state_d = ST_MU;
      end
      ST_MU: begin
        u_d     = mixv;
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (dec_q) begin
          wa_d = rc6_pkg::rotr32(wd_q - rk_even_q, u_q[4:0]) ^ t_q;
          wb_d = wa_q;
          wc_d = rc6_pkg::rotr32(wb_q - rk_odd_q, t_q[4:0]) ^ u_q;
          wd_d = wc_q;
        end else begin
          wa_d = wb_q;
          wb_d = rc6_pkg::rotl32(wc_q ^ u_q, t_q[4:0]) + rk_odd_q;
          wc_d = wd_q;
          wd_d = rc6_pkg::rotl32(wa_q ^ t_q, u_q[4:0]) + rk_even_q;
        end
        if (rnd_last) begin
          pair_d  = dec_q ? '0 : PW'(ROUNDS + 1);
          state_d = ST_POST;
        end else begin
          pair_d  = dec_q ? pair_q - PW'(1) : pair_q + PW'(1);
          state_d = ST_MT;
        end
      end
      ST_POST: begin
        if (!out_valid_q || m_axis_tready) begin
          if (dec_q) begin
            out_d = {wd_q - rk_odd_q, wc_q, wb_q - rk_even_q, wa_q};
          end else begin
            out_d = {wd_q, wc_q + rk_odd_q, wb_q, wa_q + rk_even_q};
          end
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (cfg_we_i && cfg_idx_i <= rc6_pkg::CFG_DECRYPT) begin
      ready_d = 1'b0;
    end
  end

  assign rd_pair = (state_d == ST_KSA) ? k_d[KW-1:1] : pair_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ready_q     <= 1'b0;
      out_valid_q <= 1'b0;
      k_q         <= '0;
      j_q         <= '0;
      pass_q      <= '0;
      pair_q      <= '0;
    end else begin
      state_q     <= state_d;
      ready_q     <= ready_d;
      out_valid_q <= out_valid_d;
      k_q         <= k_d;
      j_q         <= j_d;
      pass_q      <= pass_d;
      pair_q      <= pair_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        key_q[i] <= '0;
      end
      klen_q <= '0;
      dec_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i) inside
        rc6_pkg::CFG_KEY0, rc6_pkg::CFG_KEY1, rc6_pkg::CFG_KEY2, rc6_pkg::CFG_KEY3: begin
          key_q[cfg_idx_i[1:0]] <= cfg_wdata_i;
        end
        rc6_pkg::CFG_KEYLEN:  klen_q <= cfg_wdata_i[1:0];
        rc6_pkg::CFG_DECRYPT: dec_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    wa_q   <= wa_d;
    wb_q   <= wb_d;
    wc_q   <= wc_d;
    wd_q   <= wd_d;
    t_q    <= t_d;
    u_q    <= u_d;
    ka_q   <= ka_d;
    kb_q   <= kb_d;
    init_q <= init_d;
    out_q  <= out_d;
    if (lw_load) begin
      for (int i = 0; i < 8; i++) begin
        lw_q[i] <= i[0] ? key_q[i >> 1][63:32] : key_q[i >> 1][31:0];
      end
    end else if (state_q == ST_KSB) begin
      lw_q[j_q] <= kb_d;
    end
  end

  // round key banks, even and odd words
  always_ff @(posedge clk_i) begin
    if (state_q == ST_KSA) begin
      if (k_q[0]) begin
        odd_mem[k_q[KW-1:1]] <= ka_d;
      end else begin
        even_mem[k_q[KW-1:1]] <= ka_d;
      end
    end
    rk_even_q <= even_mem[rd_pair];
    rk_odd_q  <= odd_mem[rd_pair];
  end

  a_cipher_needs_keys: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PRE || state_q == ST_UPD) |-> ready_q)
    else $error("cipher running without a built key schedule");

  a_key_word_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_KSB) |-> ({1'b0, j_q} < nkw))
    else $error("key word index beyond key length");

  a_post_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POST) |-> (pair_q == (dec_q ? PW'(0) : PW'(ROUNDS + 1))))
    else $error("final whitening on wrong round key pair");

  a_out_not_overwritten: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POST && out_valid_q && !m_axis_tready) |=>
      (state_q == ST_POST && $stable(out_q)))
    else $error("pending result overwritten");

endmodule

[tb/sv/rc6_block_cipher_core_test.sv]
module rc6_block_cipher_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_ROUNDS  = 20;
  localparam int unsigned NUM_RKEYS   = 2 * NUM_ROUNDS + 4;
  localparam logic [31:0] MAGIC_P     = 32'hb7e15163;
  localparam logic [31:0] MAGIC_Q     = 32'h9e3779b9;
  localparam logic [31:0] SCHED_ROT   = 32'd3;
  localparam logic [31:0] MIX_ROT     = 32'd5;
  localparam int unsigned ITEMS       = 850;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned MAX_REPORTS = 40;

  localparam logic [1:0] KEYLEN_256   = 2'd2;
  localparam logic [1:0] KEYLEN_SPARE = 2'd3;
  localparam logic       DIR_ENCRYPT  = 1'b0;
  localparam logic       DIR_DECRYPT  = 1'b1;
  localparam logic [2:0] REG_SPARE_6  = 3'd6;
  localparam logic [2:0] REG_SPARE_7  = 3'd7;

  localparam logic [63:0]  ONES64  = {64{1'b1}};
  localparam logic [127:0] ONES128 = {128{1'b1}};
  // published vector: all-zero 128 bit key, all-zero block
  localparam logic [127:0] ZERO_KEY_CT = {64'h1ea44898_4edf29c1, 64'h78f7b156_36a5c38f};

  typedef enum logic {ROW_WRITE, ROW_BLOCK} row_kind_e;

  typedef struct {
    row_kind_e    kind;
    logic [2:0]   idx;
    logic [127:0] data;
    bit           known;
    logic [127:0] answer;
  } stim_row_t;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         cfg_we_i      = 1'b0;
  logic [2:0]   cfg_idx_i     = '0;
  logic [63:0]  cfg_wdata_i   = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata  = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;

  logic         blk_known     = 1'b0;
  logic [127:0] blk_answer    = '0;

  rc6_block_cipher_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // predictor state
  logic [63:0]  key_mirror [4];
  logic [1:0]   keylen_mirror  = rc6_pkg::KEYLEN_128;
  logic         dir_mirror     = DIR_ENCRYPT;
  logic [31:0]  round_key [NUM_RKEYS];
  bit           keys_ready     = 1'b0;
  logic [127:0] out_block_q [$];

  int unsigned  mismatches     = 0;
  int unsigned  blocks_sent    = 0;
  int unsigned  enc_blocks     = 0;
  int unsigned  dec_blocks     = 0;
  int unsigned  key_builds     = 0;
  int unsigned  len_blocks [3] = '{0, 0, 0};
  int unsigned  quiet_cycles   = 0;
  bit           steady_phase   = 1'b0;

  stim_row_t    directed_rows [$];

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [31:0] rot_left(input logic [31:0] x, input logic [31:0] n);
    logic [4:0] s;
    s = n[4:0];
    if (s == 5'd0) return x;
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic logic [31:0] rot_right(input logic [31:0] x, input logic [31:0] n);
    logic [4:0] s;
    s = n[4:0];
    if (s == 5'd0) return x;
    return (x >> s) | (x << (32 - s));
  endfunction

  function automatic logic [31:0] quad_mix(input logic [31:0] x);
    logic [31:0] p;
    p = x * ((x << 1) | 32'd1);
    return rot_left(p, MIX_ROT);
  endfunction

  task automatic expand_key();
    logic [31:0] lw [8];
    logic [31:0] a, b;
    int unsigned nw, k, j;
    nw = (keylen_mirror == rc6_pkg::KEYLEN_128) ? 4 :
         (keylen_mirror == rc6_pkg::KEYLEN_192) ? 6 : 8;
    for (int i = 0; i < 8; i++) lw[i] = key_mirror[i / 2][32 * (i % 2) +: 32];
    round_key[0] = MAGIC_P;
    for (int i = 1; i < NUM_RKEYS; i++) round_key[i] = round_key[i - 1] + MAGIC_Q;
    a = '0;
    b = '0;
    k = 0;
    j = 0;
    for (int n = 0; n < 3 * NUM_RKEYS; n++) begin
      round_key[k] = rot_left(round_key[k] + a + b, SCHED_ROT);
      a = round_key[k];
      lw[j] = rot_left(lw[j] + a + b, a + b);
      b = lw[j];
      k = (k + 1) % NUM_RKEYS;
      j = (j + 1) % nw;
    end
    keys_ready = 1'b1;
    key_builds++;
  endtask

  function automatic logic [127:0] rc6_transform(input logic [127:0] blk, input logic dir);
    logic [31:0] a, b, c, d, t, u, x;
    a = blk[31:0];
    b = blk[63:32];
    c = blk[95:64];
    d = blk[127:96];
    if (dir == DIR_ENCRYPT) begin
      b += round_key[0];
      d += round_key[1];
      for (int i = 1; i <= NUM_ROUNDS; i++) begin
        t = quad_mix(b);
        u = quad_mix(d);
        a = rot_left(a ^ t, u) + round_key[2 * i];
        c = rot_left(c ^ u, t) + round_key[2 * i + 1];
        x = a; a = b; b = c; c = d; d = x;
      end
      a += round_key[2 * NUM_ROUNDS + 2];
      c += round_key[2 * NUM_ROUNDS + 3];
    end else begin
      c -= round_key[2 * NUM_ROUNDS + 3];
      a -= round_key[2 * NUM_ROUNDS + 2];
      for (int i = NUM_ROUNDS; i >= 1; i--) begin
        x = d; d = c; c = b; b = a; a = x;
        u = quad_mix(d);
        t = quad_mix(b);
        c = rot_right(c - round_key[2 * i + 1], t) ^ u;
        a = rot_right(a - round_key[2 * i], u) ^ t;
      end
      d -= round_key[1];
      b -= round_key[0];
    end
    return {d, c, b, a};
  endfunction

  // register mirror, input and result checking, one process
  always @(posedge clk_i) begin
    logic [127:0] want;
    if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
      if (out_block_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result %h", $realtime, m_axis_tdata);
      end else begin
        want = out_block_q.pop_front();
        if (m_axis_tdata[63:0] !== want[63:0]) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result_low expected %h actual %h", $realtime,
                     want[63:0], m_axis_tdata[63:0]);
        end
        if (m_axis_tdata[127:64] !== want[127:64]) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result_high expected %h actual %h", $realtime,
                     want[127:64], m_axis_tdata[127:64]);
        end
      end
    end
    if (cfg_we_i) begin
      case (cfg_idx_i) inside
        rc6_pkg::CFG_KEY0, rc6_pkg::CFG_KEY1, rc6_pkg::CFG_KEY2, rc6_pkg::CFG_KEY3: begin
          key_mirror[cfg_idx_i[1:0]] = cfg_wdata_i;
          keys_ready = 1'b0;
        end
        rc6_pkg::CFG_KEYLEN: begin
          keylen_mirror = cfg_wdata_i[1:0];
          keys_ready = 1'b0;
        end
        rc6_pkg::CFG_DECRYPT: begin
          dir_mirror = cfg_wdata_i[0];
          keys_ready = 1'b0;
        end
        default: ;
      endcase
    end
    if (s_axis_tvalid && s_axis_tready) begin
      if (!keys_ready) expand_key();
      want = rc6_transform(s_axis_tdata, dir_mirror);
      out_block_q.push_back(blk_known ? blk_answer : want);
      if (dir_mirror == DIR_DECRYPT) dec_blocks++;
      else enc_blocks++;
      len_blocks[(keylen_mirror > KEYLEN_256) ? KEYLEN_256 : keylen_mirror]++;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid === 1'b1 && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic int unsigned pick_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 5);
    return $urandom_range(20, 150);
  endfunction

  // result side back-pressure
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
      stall = steady_phase ? 0 : pick_pause();
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  function automatic logic [31:0] rand_word32();
    case ($urandom_range(0, 15))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      2: return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] rand_word64();
    return {rand_word32(), rand_word32()};
  endfunction

  function automatic stim_row_t write_row(input logic [2:0] idx, input logic [63:0] v);
    stim_row_t r;
    r.kind = ROW_WRITE;
    r.idx = idx;
    r.data = {64'h0, v};
    r.known = 1'b0;
    r.answer = '0;
    return r;
  endfunction

  function automatic stim_row_t block_row(input logic [127:0] d, input bit known = 1'b0,
                                          input logic [127:0] ans = '0);
    stim_row_t r;
    r.kind = ROW_BLOCK;
    r.idx = '0;
    r.data = d;
    r.known = known;
    r.answer = ans;
    return r;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_block(input logic [127:0] d, input bit known, input logic [127:0] ans);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    blk_known <= known;
    blk_answer <= ans;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    blocks_sent++;
  endtask

  task automatic request_gap();
    int unsigned g;
    g = steady_phase ? 0 : pick_pause();
    if (g != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // hold off until every pending result is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (out_block_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin
    int unsigned n;
    logic [63:0] v;

    // all-zero key straight out of reset, then mixed keys and directions
    directed_rows.push_back(block_row('0, 1'b1, ZERO_KEY_CT));
    directed_rows.push_back(block_row(ONES128));
    directed_rows.push_back(block_row({64'h0, ONES64}));
    directed_rows.push_back(block_row({ONES64, 64'h0}));
    directed_rows.push_back(write_row(rc6_pkg::CFG_DECRYPT, {63'h0, DIR_DECRYPT}));
    directed_rows.push_back(block_row(ZERO_KEY_CT, 1'b1, '0));
    directed_rows.push_back(block_row(ONES128));
    directed_rows.push_back(write_row(rc6_pkg::CFG_KEY0, ONES64));
    directed_rows.push_back(write_row(rc6_pkg::CFG_KEY1, ONES64));
    directed_rows.push_back(write_row(rc6_pkg::CFG_KEY2, ONES64));
    directed_rows.push_back(write_row(rc6_pkg::CFG_KEY3, ONES64));
    // upper bits of the direction word are ignored
    directed_rows.push_back(write_row(rc6_pkg::CFG_DECRYPT,
                                      {63'h7fff_ffff_ffff_ffff, DIR_ENCRYPT}));
    directed_rows.push_back(block_row('0));
    directed_rows.push_back(block_row(ONES128));
    directed_rows.push_back(write_row(rc6_pkg::CFG_KEYLEN, {62'h0, rc6_pkg::KEYLEN_192}));
    directed_rows.push_back(block_row('0));
    directed_rows.push_back(write_row(rc6_pkg::CFG_DECRYPT, {63'h0, DIR_DECRYPT}));
    directed_rows.push_back(block_row(ONES128));
    directed_rows.push_back(write_row(rc6_pkg::CFG_KEYLEN, {62'h0, KEYLEN_256}));
    directed_rows.push_back(block_row({4{32'h5555_5555}}));
    directed_rows.push_back(write_row(rc6_pkg::CFG_DECRYPT, {63'h0, DIR_ENCRYPT}));
    directed_rows.push_back(block_row({4{32'haaaa_aaaa}}));
    // code 3 acts as a 256 bit key
    directed_rows.push_back(write_row(rc6_pkg::CFG_KEYLEN, ONES64));
    directed_rows.push_back(block_row('0));
    directed_rows.push_back(write_row(rc6_pkg::CFG_KEY2, 64'h0123_4567_89ab_cdef));
    directed_rows.push_back(write_row(REG_SPARE_6, ONES64));
    directed_rows.push_back(block_row({64'hfedc_ba98_7654_3210, 64'h0f1e_2d3c_4b5a_6978}));
    directed_rows.push_back(write_row(REG_SPARE_7, 64'h0));
    directed_rows.push_back(block_row({64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001}));
    directed_rows.push_back(write_row(rc6_pkg::CFG_KEYLEN, {62'h0, rc6_pkg::KEYLEN_128}));
    directed_rows.push_back(write_row(rc6_pkg::CFG_KEY0, 64'h8000_0000_0000_0001));
    directed_rows.push_back(write_row(rc6_pkg::CFG_KEY1, 64'h0));
    directed_rows.push_back(write_row(rc6_pkg::CFG_DECRYPT, {63'h0, DIR_DECRYPT}));
    directed_rows.push_back(block_row(ONES128));
    directed_rows.push_back(block_row('0));

    for (int i = 0; i < 4; i++) key_mirror[i] = '0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_WRITE) begin
        drain();
        write_reg(directed_rows[r].idx, directed_rows[r].data[63:0]);
      end else begin
        send_block(directed_rows[r].data, directed_rows[r].known, directed_rows[r].answer);
        request_gap();
      end
    end

    while (blocks_sent < ITEMS) begin
      drain();
      if ($urandom_range(0, 3) != 0) begin
        for (int r = rc6_pkg::CFG_KEY0; r <= rc6_pkg::CFG_KEY3; r++)
          if ($urandom_range(0, 1) != 0) write_reg(r[2:0], rand_word64());
        if ($urandom_range(0, 1) != 0) begin
          v = ($urandom_range(0, 3) == 0) ? rand_word64() : 64'h0;
          v[1:0] = 2'($urandom_range(rc6_pkg::KEYLEN_128, KEYLEN_SPARE));
          write_reg(rc6_pkg::CFG_KEYLEN, v);
        end
        if ($urandom_range(0, 1) != 0) begin
          v = ($urandom_range(0, 3) == 0) ? rand_word64() : 64'h0;
          v[0] = 1'($urandom_range(0, 1));
          write_reg(rc6_pkg::CFG_DECRYPT, v);
        end
        if ($urandom_range(0, 7) == 0)
          write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, rand_word64());
      end
      steady_phase = ($urandom_range(0, 4) == 0);
      n = $urandom_range(10, 60);
      repeat (n) begin
        send_block({rand_word32(), rand_word32(), rand_word32(), rand_word32()}, 1'b0, '0);
        if ($urandom_range(0, 49) == 0) drain();
        else request_gap();
      end
      steady_phase = 1'b0;
    end

    drain();
    repeat (400) @(posedge clk_i);

    $display("covered %0d blocks (%0d encrypt, %0d decrypt) over %0d key schedules",
             enc_blocks + dec_blocks, enc_blocks, dec_blocks, key_builds);
    $display("blocks per key size 128/192/256: %0d/%0d/%0d, %0d mismatches",
             len_blocks[0], len_blocks[1], len_blocks[2], mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[rc6_block_cipher_core.f]
rtl/rc6_pkg.sv
rtl/rc6_block_cipher_core.sv
tb/sv/rc6_block_cipher_core_test.sv
